// ===== sv/lrc_pkg.sv =====
package lrc_pkg;

  // item actions
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_FEATURE = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  // table select codes
  localparam logic [2:0] TBL_MEAN    = 3'd0;
  localparam logic [2:0] TBL_INV_STD = 3'd1;
  localparam logic [2:0] TBL_INPUT   = 3'd2;
  localparam logic [2:0] TBL_RECUR   = 3'd3;
  localparam logic [2:0] TBL_READOUT = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK_RATE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LIMIT = 4'd1;

  localparam int LEAK_W = 13;
  localparam int CLIP_W = 15;
  localparam int CFG_DATA_W = 15;
  localparam logic [LEAK_W-1:0] LEAK_ONE   = 13'd4096;
  localparam logic [CLIP_W-1:0] CLIP_RESET = 15'd12288;

  // datapath widths
  localparam int ACC_W     = 40;
  localparam int LOGIT_W   = 28;
  localparam int EXP_W     = 17;
  localparam int TOTAL_W   = 20;
  localparam int PROB_W    = 13;
  localparam int DIV_NUM_W = 29;
  localparam logic [PROB_W-1:0] PROB_ONE = 13'd4096;
  localparam logic [11:0] TANH_END = 12'd4093;
  localparam logic [EXP_W-1:0] EXP_END = 17'd22;

  typedef struct packed {
    logic              valid;
    logic [1:0]        action;
    logic [2:0]        table_select;
    logic [9:0]        index;
    logic signed [15:0] value;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [LEAK_W-1:0] leak_rate;
    logic [CLIP_W-1:0] clip_limit;
  } cfg_t;

  typedef struct packed {
    logic                      valid;
    logic                      last;
    logic signed [LOGIT_W-1:0] value;
  } logit_t;

  // tanh at steps of 0.25 over [0,4], Q0.12
  function automatic logic [11:0] tanh_tab(input logic [4:0] i);
    logic [11:0] y;
    case (i)
      5'd0:  y = 12'd0;
      5'd1:  y = 12'd1003;
      5'd2:  y = 12'd1893;
      5'd3:  y = 12'd2602;
      5'd4:  y = 12'd3119;
      5'd5:  y = 12'd3475;
      5'd6:  y = 12'd3707;
      5'd7:  y = 12'd3856;
      5'd8:  y = 12'd3949;
      5'd9:  y = 12'd4006;
      5'd10: y = 12'd4041;
      5'd11: y = 12'd4062;
      5'd12: y = 12'd4076;
      5'd13: y = 12'd4084;
      5'd14: y = 12'd4089;
      5'd15: y = 12'd4091;
      default: y = 12'd4093;
    endcase
    return y;
  endfunction

  // exp(-t) at steps of 0.5 over [0,8], Q1.16
  function automatic logic [EXP_W-1:0] exp_tab(input logic [4:0] i);
    logic [EXP_W-1:0] y;
    case (i)
      5'd0:  y = 17'd65536;
      5'd1:  y = 17'd39750;
      5'd2:  y = 17'd24109;
      5'd3:  y = 17'd14623;
      5'd4:  y = 17'd8869;
      5'd5:  y = 17'd5380;
      5'd6:  y = 17'd3263;
      5'd7:  y = 17'd1979;
      5'd8:  y = 17'd1200;
      5'd9:  y = 17'd728;
      5'd10: y = 17'd442;
      5'd11: y = 17'd268;
      5'd12: y = 17'd162;
      5'd13: y = 17'd99;
      5'd14: y = 17'd60;
      5'd15: y = 17'd36;
      default: y = 17'd22;
    endcase
    return y;
  endfunction

endpackage

// ===== sv/leaky_reservoir_classifier.sv =====
// channel   | handshake            | payload
// item      | item_valid, item_stall | action, table_select, index, value, last
// result    | result_valid, result_stall | class_number, probability, final_res,
//           |                      | predicted_class, confidence, alert_probability
// config    | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// load, clear and non-last feature items are accepted without raising item_stall.
// a last feature item holds item_stall while the prediction runs through the single
// multiply-accumulate unit and the bit-serial probability divider.
// the reservoir state is cleared at reset through per-entry valid bits.
// a stalled result holds the output register; the last result frees the item side.
module leaky_reservoir_classifier #(
  parameter int FEATURE_COUNT   = 8,
  parameter int RESERVOIR_UNITS = 32,
  parameter int CLASS_COUNT     = 3
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic [1:0]                         action,
  input  logic [2:0]                         table_select,
  input  logic [9:0]                         index,
  input  logic signed [15:0]                 value,
  input  logic                               last,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [2:0]                         class_number,
  output logic [lrc_pkg::PROB_W-1:0]         probability,
  output logic                               final_res,
  output logic [2:0]                         predicted_class,
  output logic [lrc_pkg::PROB_W-1:0]         confidence,
  output logic [lrc_pkg::PROB_W-1:0]         alert_probability,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lrc_pkg::cfg_t   cfg;
  lrc_pkg::item_t  item;
  lrc_pkg::logit_t logit;
  logic core_busy, sm_busy;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leak_rate  <= lrc_pkg::LEAK_ONE;
      cfg.clip_limit <= lrc_pkg::CLIP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lrc_pkg::CFG_LEAK_RATE:  cfg.leak_rate  <= cfg_data[lrc_pkg::LEAK_W-1:0];
        lrc_pkg::CFG_CLIP_LIMIT: cfg.clip_limit <= cfg_data[lrc_pkg::CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // item transfer
  assign item_stall        = core_busy || sm_busy;
  assign item.valid        = item_valid && !item_stall;
  assign item.action       = action;
  assign item.table_select = table_select;
  assign item.index        = index;
  assign item.value        = value;
  assign item.last         = last;

  lrc_core #(
    .F(FEATURE_COUNT), .R(RESERVOIR_UNITS), .C(CLASS_COUNT)
  ) u_core (
    .clk(clk), .rst(rst), .item(item), .cfg(cfg), .busy(core_busy), .logit(logit));

  lrc_softmax #(.C(CLASS_COUNT)) u_softmax (
    .clk(clk), .rst(rst), .logit(logit), .busy(sm_busy),
    .result_valid(result_valid), .result_stall(result_stall),
    .class_number(class_number), .probability(probability), .final_res(final_res),
    .predicted_class(predicted_class), .confidence(confidence),
    .alert_probability(alert_probability));

endmodule

// ===== sv/lrc_ram.sv =====
module lrc_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lrc_div.sv =====
module lrc_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [lrc_pkg::DIV_NUM_W-1:0]   num,
  input  logic [lrc_pkg::TOTAL_W-1:0]     den,
  output logic                            done,
  output logic [lrc_pkg::DIV_NUM_W-1:0]   quo
);

  localparam int NW = lrc_pkg::DIV_NUM_W;
  localparam int DW = lrc_pkg::TOTAL_W;
  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dsr;
  logic [DW:0]     shifted;

  assign shifted = {rem, quo[NW-1]};

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNTW'(NW);
        rem <= '0;
        quo <= num;
        dsr <= den;
      end else if (cnt != '0) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          done <= 1'b1;
        end
        if (shifted >= {1'b0, dsr}) begin
          rem <= DW'(shifted - {1'b0, dsr});
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= shifted[DW-1:0];
          quo <= {quo[NW-2:0], 1'b0};
        end
      end
    end
  end

endmodule

// ===== sv/lrc_core.sv =====
module lrc_core #(
  parameter int F = 8,
  parameter int R = 32,
  parameter int C = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  lrc_pkg::item_t  item,
  input  lrc_pkg::cfg_t   cfg,
  output logic            busy,
  output lrc_pkg::logit_t logit
);

  localparam int IN_ROW   = F + 1;
  localparam int IN_SIZE  = R * IN_ROW;
  localparam int REC_SIZE = R * R;
  localparam int DLEN     = 1 + F + R;
  localparam int OUT_SIZE = C * DLEN;
  localparam int FAW   = (F > 1) ? $clog2(F) : 1;
  localparam int WIA   = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
  localparam int WRA   = (REC_SIZE > 1) ? $clog2(REC_SIZE) : 1;
  localparam int WOA   = $clog2(OUT_SIZE);
  localparam int RESAW = $clog2(2 * R);
  localparam int FCW   = $clog2(F + 1);
  localparam int TW    = $clog2(DLEN + 1);
  localparam int RCW   = $clog2(R + 1);
  localparam int CW    = $clog2(C + 1);
  localparam int ACC_W = lrc_pkg::ACC_W;
  localparam int ACT_W = lrc_pkg::LOGIT_W;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_NRD  = 13'b0000000000010,
    S_NMUL = 13'b0000000000100,
    S_NWR  = 13'b0000000001000,
    S_RISS = 13'b0000000010000,
    S_RDRN = 13'b0000000100000,
    S_RF0  = 13'b0000001000000,
    S_RF1  = 13'b0000010000000,
    S_RF2  = 13'b0000100000000,
    S_RF3  = 13'b0001000000000,
    S_OISS = 13'b0010000000000,
    S_ODRN = 13'b0100000000000,
    S_OLOG = 13'b1000000000000
  } state_t;

  typedef enum logic [1:0] {SRC_ONE, SRC_NORM, SRC_RES} src_t;
  typedef enum logic [1:0] {WT_IN, WT_REC, WT_OUT} wsel_t;

  state_t state;
  logic [FCW-1:0] c;
  logic [TW-1:0]  j;
  logic [RCW-1:0] r;
  logic [CW-1:0]  k;
  logic [WIA-1:0] win_addr;
  logic [WRA-1:0] rec_addr;
  logic [WOA-1:0] wout_addr;
  logic           bank;

  // table writes from accepted load and feature items
  logic is_load, is_feat;
  logic mean_we, inv_we, feat_we, win_we, wrec_we, wout_we;
  logic start;

  assign is_load = item.valid && item.action == lrc_pkg::ACT_LOAD;
  assign is_feat = item.valid && item.action == lrc_pkg::ACT_FEATURE;
  assign mean_we = is_load && item.table_select == lrc_pkg::TBL_MEAN
                   && {22'd0, item.index} < 32'(F);
  assign inv_we  = is_load && item.table_select == lrc_pkg::TBL_INV_STD
                   && {22'd0, item.index} < 32'(F);
  assign win_we  = is_load && item.table_select == lrc_pkg::TBL_INPUT
                   && {22'd0, item.index} < 32'(IN_SIZE);
  assign wrec_we = is_load && item.table_select == lrc_pkg::TBL_RECUR
                   && {22'd0, item.index} < 32'(REC_SIZE);
  assign wout_we = is_load && item.table_select == lrc_pkg::TBL_READOUT
                   && {22'd0, item.index} < 32'(OUT_SIZE);
  assign feat_we = is_feat && {22'd0, item.index} < 32'(F);
  assign start   = is_feat && item.last;

  // memory read ports
  logic [FAW-1:0]   f_raddr, norm_raddr;
  logic [WIA-1:0]   win_raddr;
  logic [WRA-1:0]   rec_raddr;
  logic [WOA-1:0]   wout_raddr;
  logic [RESAW-1:0] res_raddr, res_waddr;
  logic [15:0] feat_rd, mean_rd, inv_rd, norm_rd, win_rd, rec_rd, wout_rd, res_rd;
  logic        norm_we, res_we;
  logic [15:0] norm_wd, res_wd;
  logic [2*R-1:0] res_vld;
  logic           res_vld_q;

  lrc_ram #(.DEPTH(F), .WIDTH(16)) u_feat (
    .clk(clk), .we(feat_we), .waddr(FAW'(item.index)), .wdata(item.value),
    .raddr(f_raddr), .rdata(feat_rd));
  lrc_ram #(.DEPTH(F), .WIDTH(16)) u_mean (
    .clk(clk), .we(mean_we), .waddr(FAW'(item.index)), .wdata(item.value),
    .raddr(f_raddr), .rdata(mean_rd));
  lrc_ram #(.DEPTH(F), .WIDTH(16)) u_inv (
    .clk(clk), .we(inv_we), .waddr(FAW'(item.index)), .wdata(item.value),
    .raddr(f_raddr), .rdata(inv_rd));
  lrc_ram #(.DEPTH(F), .WIDTH(16)) u_norm (
    .clk(clk), .we(norm_we), .waddr(FAW'(c)), .wdata(norm_wd),
    .raddr(norm_raddr), .rdata(norm_rd));
  lrc_ram #(.DEPTH(IN_SIZE), .WIDTH(16)) u_win (
    .clk(clk), .we(win_we), .waddr(WIA'(item.index)), .wdata(item.value),
    .raddr(win_raddr), .rdata(win_rd));
  lrc_ram #(.DEPTH(REC_SIZE), .WIDTH(16)) u_wrec (
    .clk(clk), .we(wrec_we), .waddr(WRA'(item.index)), .wdata(item.value),
    .raddr(rec_raddr), .rdata(rec_rd));
  lrc_ram #(.DEPTH(OUT_SIZE), .WIDTH(16)) u_wout (
    .clk(clk), .we(wout_we), .waddr(WOA'(item.index)), .wdata(item.value),
    .raddr(wout_raddr), .rdata(wout_rd));
  lrc_ram #(.DEPTH(2 * R), .WIDTH(16)) u_res (
    .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wd),
    .raddr(res_raddr), .rdata(res_rd));

  // issue stage: term j of the current row
  logic        iss_valid;
  src_t        iss_src;
  wsel_t       iss_wsel;
  logic [RESAW-1:0] unit_term;
  logic [RESAW-1:0] bank_base, other_base;

  assign unit_term  = RESAW'(j) - RESAW'(F + 1);
  assign bank_base  = bank ? RESAW'(R) : '0;
  assign other_base = bank ? '0 : RESAW'(R);
  assign f_raddr    = FAW'(c);
  assign norm_raddr = FAW'(j) - FAW'(1);
  assign win_raddr  = win_addr;
  assign rec_raddr  = rec_addr;
  assign wout_raddr = wout_addr;
  assign res_waddr  = other_base + RESAW'(r);

  always_comb begin
    iss_valid = (state == S_RISS) || (state == S_OISS);
    if (j == '0) begin
      iss_src = SRC_ONE;
    end else if (j <= TW'(F)) begin
      iss_src = SRC_NORM;
    end else begin
      iss_src = SRC_RES;
    end
    if (state == S_OISS) begin
      iss_wsel = WT_OUT;
    end else if (j <= TW'(F)) begin
      iss_wsel = WT_IN;
    end else begin
      iss_wsel = WT_REC;
    end
    if (state == S_RF0) begin
      res_raddr = bank_base + RESAW'(r);
    end else begin
      res_raddr = bank_base + unit_term;
    end
  end

  // multiply-accumulate pipeline
  logic               s1_valid, s2_valid;
  src_t               s1_src;
  wsel_t              s1_wsel;
  logic signed [15:0] mul_w, mul_x;
  logic signed [31:0] prod;
  logic signed [ACC_W-1:0] acc, acc_rnd;
  logic signed [ACT_W-1:0] act;

  always_comb begin
    case (s1_wsel)
      WT_IN:   mul_w = win_rd;
      WT_REC:  mul_w = rec_rd;
      default: mul_w = wout_rd;
    endcase
    case (s1_src)
      SRC_ONE:  mul_x = 16'sd4096;
      SRC_NORM: mul_x = norm_rd;
      default:  mul_x = res_vld_q ? res_rd : 16'sd0;
    endcase
  end

  assign acc_rnd = acc + ACC_W'(2048);
  assign act     = ACT_W'(acc_rnd >>> 12);

  // normalization
  logic signed [16:0] ndiff;
  logic signed [32:0] nprod, nrnd, nlim;

  assign ndiff   = {feat_rd[15], feat_rd} - {mean_rd[15], mean_rd};
  assign nrnd    = (nprod + 33'sd128) >>> 8;
  assign nlim    = $signed({18'd0, cfg.clip_limit});
  assign norm_we = (state == S_NWR);

  always_comb begin
    if (nrnd > nlim) begin
      norm_wd = 16'(nlim);
    end else if (nrnd < -nlim) begin
      norm_wd = 16'(-nlim);
    end else begin
      norm_wd = 16'(nrnd);
    end
  end

  // tanh and leak
  logic [ACT_W-1:0]  mag;
  logic              t_neg, t_big;
  logic [11:0]       t_base, t_diff, t_y_mag;
  logic [9:0]        t_frac;
  logic [21:0]       t_p;
  logic signed [12:0] t_y;
  logic signed [15:0] xr;
  logic [LEAK_W_L-1:0] a_eff;
  localparam int LEAK_W_L = lrc_pkg::LEAK_W;
  logic [LEAK_W_L-1:0] oma;
  logic signed [29:0] p1, p2;
  logic signed [30:0] psum;

  assign mag     = act[ACT_W-1] ? ACT_W'(-act) : ACT_W'(act);
  assign t_p     = 22'(t_diff) * 22'(t_frac);
  assign t_y_mag = t_big ? lrc_pkg::TANH_END : t_base + 12'((t_p + 22'd512) >> 10);
  assign a_eff   = (cfg.leak_rate > lrc_pkg::LEAK_ONE) ? lrc_pkg::LEAK_ONE : cfg.leak_rate;
  assign oma     = lrc_pkg::LEAK_ONE - a_eff;
  assign psum    = 31'(p1) + 31'(p2) + 31'sd2048;
  assign res_wd  = 16'(psum >>> 12);
  assign res_we  = (state == S_RF3);

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      bank     <= 1'b0;
      res_vld  <= '0;
    end else begin
      s1_valid <= iss_valid;
      s2_valid <= s1_valid;
      if (res_we) begin
        res_vld[res_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (item.valid && item.action == lrc_pkg::ACT_CLEAR) begin
            res_vld <= '0;
          end
          if (start) begin
            state <= S_NRD;
          end
        end
        S_NRD:  state <= S_NMUL;
        S_NMUL: state <= S_NWR;
        S_NWR: begin
          state <= (c == FCW'(F - 1)) ? S_RISS : S_NRD;
        end
        S_RISS: begin
          if (j == TW'(F + R)) begin
            state <= S_RDRN;
          end
        end
        S_RDRN: begin
          if (!s1_valid && !s2_valid) begin
            state <= S_RF0;
          end
        end
        S_RF0: state <= S_RF1;
        S_RF1: state <= S_RF2;
        S_RF2: state <= S_RF3;
        S_RF3: begin
          if (r == RCW'(R - 1)) begin
            bank  <= ~bank;
            state <= S_OISS;
          end else begin
            state <= S_RISS;
          end
        end
        S_OISS: begin
          if (j == TW'(DLEN - 1)) begin
            state <= S_ODRN;
          end
        end
        S_ODRN: begin
          if (!s1_valid && !s2_valid) begin
            state <= S_OLOG;
          end
        end
        S_OLOG: begin
          state <= (k == CW'(C - 1)) ? S_IDLE : S_OISS;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // counters, addresses and payload
  always_ff @(posedge clk) begin
    s1_src    <= iss_src;
    s1_wsel   <= iss_wsel;
    res_vld_q <= res_vld[res_raddr];
    prod      <= mul_w * mul_x;
    if (s2_valid) begin
      acc <= acc + ACC_W'(prod);
    end
    if (iss_valid && j == '0) begin
      acc <= '0;
    end
    if (iss_valid) begin
      case (iss_wsel)
        WT_IN:   win_addr <= win_addr + WIA'(1);
        WT_REC:  rec_addr <= rec_addr + WRA'(1);
        default: wout_addr <= wout_addr + WOA'(1);
      endcase
    end
    case (state)
      S_IDLE: begin
        c         <= '0;
        j         <= '0;
        r         <= '0;
        k         <= '0;
        win_addr  <= '0;
        rec_addr  <= '0;
        wout_addr <= '0;
      end
      S_NMUL: nprod <= ndiff * $signed(inv_rd);
      S_NWR:  c <= c + FCW'(1);
      S_RISS: j <= (j == TW'(F + R)) ? '0 : j + TW'(1);
      S_OISS: j <= (j == TW'(DLEN - 1)) ? '0 : j + TW'(1);
      S_RF0: begin
        t_neg  <= act[ACT_W-1];
        t_big  <= |mag[ACT_W-1:14];
        t_base <= lrc_pkg::tanh_tab({1'b0, mag[13:10]});
        t_diff <= lrc_pkg::tanh_tab({1'b0, mag[13:10]} + 5'd1)
                  - lrc_pkg::tanh_tab({1'b0, mag[13:10]});
        t_frac <= mag[9:0];
      end
      S_RF1: begin
        t_y <= t_neg ? -$signed({1'b0, t_y_mag}) : $signed({1'b0, t_y_mag});
        xr  <= res_vld_q ? res_rd : 16'sd0;
      end
      S_RF2: begin
        p1 <= $signed({1'b0, oma}) * xr;
        p2 <= $signed({1'b0, a_eff}) * t_y;
      end
      S_RF3: begin
        if (r != RCW'(R - 1)) begin
          r <= r + RCW'(1);
        end
      end
      S_OLOG: k <= k + CW'(1);
      default: ;
    endcase
  end

  assign busy        = (state != S_IDLE);
  assign logit.valid = (state == S_OLOG);
  assign logit.last  = (k == CW'(C - 1));
  assign logit.value = act;

`ifndef NO_ASSERTIONS
  a_logit_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_OLOG |-> !s1_valid && !s2_valid)
    else $error("logit taken before the accumulator drained");
  a_bank_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_RF3 && r != RCW'(R - 1)) |=> bank == $past(bank))
    else $error("reservoir bank flipped before the last unit");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.action == lrc_pkg::ACT_FEATURE && item.last) |=> state == S_NRD)
    else $error("last feature did not start a prediction");
`endif

endmodule

// ===== sv/lrc_softmax.sv =====
module lrc_softmax #(
  parameter int C = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lrc_pkg::logit_t               logit,
  output logic                          busy,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [2:0]                    class_number,
  output logic [lrc_pkg::PROB_W-1:0]    probability,
  output logic                          final_res,
  output logic [2:0]                    predicted_class,
  output logic [lrc_pkg::PROB_W-1:0]    confidence,
  output logic [lrc_pkg::PROB_W-1:0]    alert_probability
);

  localparam int CW = $clog2(C + 1);
  localparam int LW = lrc_pkg::LOGIT_W;
  localparam int EW = lrc_pkg::EXP_W;
  localparam int PW = lrc_pkg::PROB_W;
  localparam int TOTW = lrc_pkg::TOTAL_W;
  localparam int NW = lrc_pkg::DIV_NUM_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_E0     = 6'b000010,
    S_E1     = 6'b000100,
    S_DSTART = 6'b001000,
    S_DWAIT  = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state;
  logic [CW-1:0] cnt, k;
  logic signed [LW-1:0] lg [C];
  logic signed [LW-1:0] mx;
  logic [EW-1:0]   ex [C];
  logic [PW-1:0]   prob [C];
  logic [TOTW-1:0] total;
  logic            e_big;
  logic [EW-1:0]   e_base;
  logic [15:0]     e_diff;
  logic [10:0]     e_frac;
  logic [PW-1:0]   conf, alert;
  logic [2:0]      pred;

  // exp of the distance to the maximum logit
  logic [LW:0]    m;
  logic [26:0]    e_p;
  logic [EW-1:0]  exv;
  logic [4:0]     e_idx;

  assign m     = $unsigned({mx[LW-1], mx} - {lg[k][LW-1], lg[k]});
  assign e_idx = {1'b0, m[14:11]};
  assign e_p   = 27'(e_diff) * 27'(e_frac);
  assign exv   = e_big ? lrc_pkg::EXP_END : e_base - EW'((e_p + 27'd1024) >> 11);

  // probability division
  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [PW-1:0] pv;
  logic [PW:0]   alert_sum;

  assign div_start = (state == S_DSTART);
  assign div_num   = NW'({ex[k], 12'd0}) + NW'(total >> 1);
  assign pv        = div_quo[PW-1:0];
  assign alert_sum = {1'b0, alert} + {1'b0, pv};

  lrc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(total),
    .done(div_done), .quo(div_quo));

  // output register transfer
  logic out_free;
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      cnt          <= '0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (logit.valid) begin
            cnt <= logit.last ? '0 : cnt + CW'(1);
            if (logit.last) begin
              state <= S_E0;
            end
          end
        end
        S_E0: state <= S_E1;
        S_E1: state <= (k == CW'(C - 1)) ? S_DSTART : S_E0;
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            state <= (k == CW'(C - 1)) ? S_EMIT : S_DSTART;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            if (k == CW'(C - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        k     <= '0;
        total <= '0;
        if (logit.valid) begin
          lg[cnt] <= logit.value;
          if (cnt == '0 || logit.value > mx) begin
            mx <= logit.value;
          end
        end
      end
      S_E0: begin
        e_big  <= |m[LW:15];
        e_base <= lrc_pkg::exp_tab(e_idx);
        e_diff <= 16'(lrc_pkg::exp_tab(e_idx) - lrc_pkg::exp_tab(e_idx + 5'd1));
        e_frac <= m[10:0];
      end
      S_E1: begin
        ex[k] <= exv;
        total <= total + TOTW'(exv);
        k     <= (k == CW'(C - 1)) ? '0 : k + CW'(1);
      end
      S_DWAIT: begin
        if (div_done) begin
          prob[k] <= pv;
          if (k == '0 || pv > conf) begin
            conf <= pv;
            pred <= 3'(k);
          end
          if (k == CW'(1)) begin
            alert <= pv;
          end
          if (k == CW'(2)) begin
            alert <= (alert_sum > {1'b0, lrc_pkg::PROB_ONE}) ? lrc_pkg::PROB_ONE
                                                              : alert_sum[PW-1:0];
          end
          k <= (k == CW'(C - 1)) ? '0 : k + CW'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          class_number      <= 3'(k);
          probability       <= prob[k];
          final_res         <= (k == CW'(C - 1));
          predicted_class   <= (k == CW'(C - 1)) ? pred : 3'd0;
          confidence        <= (k == CW'(C - 1)) ? conf : '0;
          alert_probability <= (k == CW'(C - 1)) ? alert : '0;
          k                 <= k + CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule
